// ===== rtl/rlpe_pkg.sv =====
// ----------------------------------------------------------------------------
// rlpe_pkg
// Shared types and constants for the RGB LED pattern engine.
// ----------------------------------------------------------------------------
package rlpe_pkg;

    // item kinds
    typedef enum logic [3:0] {
        KIND_TICK  = 4'd0,
        KIND_SET   = 4'd1,
        KIND_ALL   = 4'd2,
        KIND_OFF   = 4'd3,
        KIND_FADE  = 4'd4,
        KIND_STOP  = 4'd5,
        KIND_BLINK = 4'd6,
        KIND_PULSE = 4'd7,
        KIND_CHASE = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        PAT_NONE  = 2'd0,
        PAT_BLINK = 2'd1,
        PAT_PULSE = 2'd2,
        PAT_CHASE = 2'd3
    } pat_mode_t;

    // configuration register indexes
    localparam logic CFG_COMMON_ANODE  = 1'b0;
    localparam logic CFG_START_CHANNEL = 1'b1;

    // quotient bits of the progress division
    localparam int CURVE_QW = 17;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FADE_PREP,
        ST_FADE_START,
        ST_FADE_WAIT,
        ST_FADE_MIX,
        ST_PAT_PREP,
        ST_PULSE_START,
        ST_PULSE_WAIT,
        ST_PULSE_MIX,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        CP_IDLE,
        CP_DIV1,
        CP_SCALE,
        CP_SQ,
        CP_H1,
        CP_H2,
        CP_H3,
        CP_H4,
        CP_DONE
    } curve_phase_t;

    typedef struct packed {
        logic ready;
        logic load;
        logic decode;
        logic fade_prep;
        logic curve_start;
        logic fade_mix;
        logic pat_prep;
        logic pulse_mix;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic fade_curve;
        logic pulse_curve;
        logic curve_done;
        logic emit_go;
        logic emit_end;
    } dp_status_t;

endpackage

// ===== rtl/rlpe_curve.sv =====
// ----------------------------------------------------------------------------
// rlpe_curve
// Quarter-sine easing unit: one restoring division, a reciprocal scale, then a
// Horner polynomial on one shared multiplier. Q16 result, clamped to 65536.
// ----------------------------------------------------------------------------
module rlpe_curve #(
    parameter int SINE_STEPS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] e_in,
    input  logic [31:0] len_in,
    output logic        done,
    output logic [16:0] c_out
);

    localparam int QW = rlpe_pkg::CURVE_QW;
    localparam int NW = 32 + QW;
    // x = floor(p*65536/S) = (p * ceil(2^36/S)) >> 20, exact for p < S <= 1024
    localparam logic [32:0] RECIP =
        33'(((64'd1 << 36) + 64'(SINE_STEPS) - 64'd1) / 64'(SINE_STEPS));

    rlpe_pkg::curve_phase_t phase_reg, phase_next;

    logic [4:0]    cnt_reg, cnt_next;
    logic [31:0]   rem_reg, rem_next;
    logic [QW-1:0] low_reg, low_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [31:0]   div_reg, div_next;
    logic [15:0]   x_reg, x_next;
    logic [15:0]   x2_reg, x2_next;
    logic [16:0]   h_reg, h_next;
    logic [16:0]   c_reg, c_next;

    logic [NW-1:0] n1;
    logic [32:0]   trial;
    logic [32:0]   shifted;
    logic          qbit;
    logic [31:0]   rem_step;
    logic [QW-1:0] quo_step;
    logic [16:0]   mul_a, mul_b;
    logic [33:0]   prod;
    logic [42:0]   scaled;
    logic          last_step;

    assign n1       = NW'(e_in) * NW'(SINE_STEPS);
    assign shifted  = {rem_reg, low_reg[QW-1]};
    assign trial    = shifted - {1'b0, div_reg};
    assign qbit     = ~trial[32];
    assign rem_step = qbit ? trial[31:0] : shifted[31:0];
    assign quo_step = {quo_reg[QW-2:0], qbit};
    assign last_step = (cnt_reg == 5'(QW - 1));
    assign prod     = 34'(mul_a) * 34'(mul_b);
    assign scaled   = 43'(quo_reg[9:0]) * 43'(RECIP);

    always_comb
    begin
        case (phase_reg)
            rlpe_pkg::CP_SQ:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, x_reg};
            end
            rlpe_pkg::CP_H1:
            begin
                mul_a = {1'b0, x2_reg};
                mul_b = 17'd307;
            end
            rlpe_pkg::CP_H2, rlpe_pkg::CP_H3:
            begin
                mul_a = {1'b0, x2_reg};
                mul_b = h_reg;
            end
            rlpe_pkg::CP_H4:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = h_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            rlpe_pkg::CP_IDLE:  if (start) phase_next = rlpe_pkg::CP_DIV1;
            rlpe_pkg::CP_DIV1:  if (last_step) phase_next = rlpe_pkg::CP_SCALE;
            rlpe_pkg::CP_SCALE: phase_next = rlpe_pkg::CP_SQ;
            rlpe_pkg::CP_SQ:    phase_next = rlpe_pkg::CP_H1;
            rlpe_pkg::CP_H1:    phase_next = rlpe_pkg::CP_H2;
            rlpe_pkg::CP_H2:    phase_next = rlpe_pkg::CP_H3;
            rlpe_pkg::CP_H3:    phase_next = rlpe_pkg::CP_H4;
            rlpe_pkg::CP_H4:    phase_next = rlpe_pkg::CP_DONE;
            rlpe_pkg::CP_DONE:  phase_next = rlpe_pkg::CP_IDLE;
            default:            phase_next = rlpe_pkg::CP_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        low_next = low_reg;
        quo_next = quo_reg;
        div_next = div_reg;
        x_next   = x_reg;
        x2_next  = x2_reg;
        h_next   = h_reg;
        c_next   = c_reg;
        case (phase_reg)
            rlpe_pkg::CP_IDLE:
            begin
                if (start)
                begin
                    // p = floor(e*S/len); high part of e*S is below len
                    rem_next = n1[NW-1:QW];
                    low_next = n1[QW-1:0];
                    div_next = len_in;
                    quo_next = '0;
                    cnt_next = '0;
                end
            end
            rlpe_pkg::CP_DIV1:
            begin
                rem_next = rem_step;
                low_next = {low_reg[QW-2:0], 1'b0};
                quo_next = quo_step;
                cnt_next = cnt_reg + 5'd1;
            end
            rlpe_pkg::CP_SCALE: x_next = scaled[35:20];
            rlpe_pkg::CP_SQ: x2_next = prod[31:16];
            rlpe_pkg::CP_H1: h_next = 17'(17'd5223 - prod[32:16]);
            rlpe_pkg::CP_H2: h_next = 17'(17'd42334 - prod[32:16]);
            rlpe_pkg::CP_H3: h_next = 17'(17'd102944 - prod[32:16]);
            rlpe_pkg::CP_H4:
                c_next = (prod[33:16] > 18'd65536) ? 17'd65536 : prod[32:16];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= rlpe_pkg::CP_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        x_reg   <= x_next;
        x2_reg  <= x2_next;
        h_reg   <= h_next;
        c_reg   <= c_next;
    end

    assign done  = (phase_reg == rlpe_pkg::CP_DONE);
    assign c_out = c_reg;

endmodule

// ===== rtl/rlpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlpe_ctrl
// Item sequencer: decode, fade and pulse curve runs, then LED write emission.
// ----------------------------------------------------------------------------
module rlpe_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  rlpe_pkg::dp_status_t   status,
    output rlpe_pkg::ctrl_cmd_t    cmd
);

    rlpe_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rlpe_pkg::ST_IDLE:
                if (in_valid) state_next = rlpe_pkg::ST_DECODE;
            rlpe_pkg::ST_DECODE:
                state_next = status.is_tick ? rlpe_pkg::ST_FADE_PREP : rlpe_pkg::ST_EMIT;
            rlpe_pkg::ST_FADE_PREP:
                state_next = status.fade_curve ? rlpe_pkg::ST_FADE_START
                                               : rlpe_pkg::ST_PAT_PREP;
            rlpe_pkg::ST_FADE_START:
                state_next = rlpe_pkg::ST_FADE_WAIT;
            rlpe_pkg::ST_FADE_WAIT:
                if (status.curve_done) state_next = rlpe_pkg::ST_FADE_MIX;
            rlpe_pkg::ST_FADE_MIX:
                state_next = rlpe_pkg::ST_PAT_PREP;
            rlpe_pkg::ST_PAT_PREP:
                state_next = status.pulse_curve ? rlpe_pkg::ST_PULSE_START
                                                : rlpe_pkg::ST_EMIT;
            rlpe_pkg::ST_PULSE_START:
                state_next = rlpe_pkg::ST_PULSE_WAIT;
            rlpe_pkg::ST_PULSE_WAIT:
                if (status.curve_done) state_next = rlpe_pkg::ST_PULSE_MIX;
            rlpe_pkg::ST_PULSE_MIX:
                state_next = rlpe_pkg::ST_EMIT;
            rlpe_pkg::ST_EMIT:
                if (status.emit_go && status.emit_end) state_next = rlpe_pkg::ST_IDLE;
            default:
                state_next = rlpe_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.ready       = (state_reg == rlpe_pkg::ST_IDLE);
        cmd.load        = (state_reg == rlpe_pkg::ST_IDLE) && in_valid;
        cmd.decode      = (state_reg == rlpe_pkg::ST_DECODE);
        cmd.fade_prep   = (state_reg == rlpe_pkg::ST_FADE_PREP);
        cmd.curve_start = (state_reg == rlpe_pkg::ST_FADE_START) ||
                          (state_reg == rlpe_pkg::ST_PULSE_START);
        cmd.fade_mix    = (state_reg == rlpe_pkg::ST_FADE_MIX);
        cmd.pat_prep    = (state_reg == rlpe_pkg::ST_PAT_PREP);
        cmd.pulse_mix   = (state_reg == rlpe_pkg::ST_PULSE_MIX);
        cmd.emit        = (state_reg == rlpe_pkg::ST_EMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rlpe_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/rlpe_dp.sv =====
// ----------------------------------------------------------------------------
// rlpe_dp
// Datapath: LED colours, fade and pattern state, write list, output register.
// ----------------------------------------------------------------------------
module rlpe_dp #(
    parameter int LED_COUNT  = 5,
    parameter int SINE_STEPS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rlpe_pkg::ctrl_cmd_t  cmd,
    output rlpe_pkg::dp_status_t status,
    input  logic [3:0]           kind,
    input  logic [31:0]          now_ms,
    input  logic [7:0]           led_index,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    input  logic [31:0]          time_first,
    input  logic [31:0]          time_second,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [3:0]           cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [3:0]           written_led,
    output logic [5:0]           first_channel,
    output logic [11:0]          red_pwm,
    output logic [11:0]          green_pwm,
    output logic [11:0]          blue_pwm,
    output logic                 last
);

    localparam int NMAX = (LED_COUNT > 3) ? LED_COUNT : 3;
    localparam int IW   = $clog2(NMAX);
    localparam int LIW  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [3:0] LAST_LED = 4'(LED_COUNT - 1);

    // configuration
    logic        anode_reg;
    logic [3:0]  start_chan_reg;

    // item
    logic [3:0]  kind_reg;
    logic [31:0] now_reg;
    logic [7:0]  led_reg;
    logic [23:0] color_reg;
    logic [31:0] t1_reg, t2_reg;

    logic [23:0] retained_reg [LED_COUNT];

    // fade
    logic        fade_act_reg, fade_act_next;
    logic [3:0]  fade_led_reg, fade_led_next;
    logic [23:0] fade_from_reg, fade_from_next;
    logic [23:0] fade_to_reg, fade_to_next;
    logic [31:0] fade_begin_reg, fade_begin_next;
    logic [31:0] fade_len_reg, fade_len_next;

    // pattern
    rlpe_pkg::pat_mode_t mode_reg, mode_next;
    logic [7:0]  pat_led_reg, pat_led_next;
    logic [23:0] pat_color_reg, pat_color_next;
    logic [31:0] pat_t1_reg, pat_t1_next;
    logic [31:0] pat_t2_reg, pat_t2_next;
    logic [31:0] deadline_reg, deadline_next;
    logic        off_phase_reg, off_phase_next;
    logic [3:0]  chase_pos_reg, chase_pos_next;
    logic [31:0] pulse_begin_reg, pulse_begin_next;
    logic        rising_reg, rising_next;
    logic [23:0] pulse_last_reg, pulse_last_next;

    // curve operands
    logic [31:0] curve_e_reg, curve_e_next;
    logic [31:0] curve_len_reg, curve_len_next;

    // write list
    logic        loop_reg, loop_next;
    logic [23:0] loop_color_reg, loop_color_next;
    logic [2:0]  slot_v_reg, slot_v_next;
    logic [3:0]  slot_led_reg [3];
    logic [3:0]  slot_led_next [3];
    logic [23:0] slot_col_reg [3];
    logic [23:0] slot_col_next [3];
    logic [IW-1:0] idx_reg, idx_next;

    // output register
    logic        out_v_reg;
    logic [3:0]  out_led_reg;
    logic [5:0]  out_chan_reg;
    logic [11:0] out_r_reg, out_g_reg, out_b_reg;
    logic        out_last_reg;

    logic [16:0] c_val;
    logic        curve_done;
    logic [31:0] fade_e, pulse_e, blink_diff;
    logic        fade_snap, is_due;
    logic [23:0] eased, pulsed;
    logic [16:0] inten;
    logic [3:0]  ch_pos, ch_prev, ch_nxt;
    logic        pat_led_ok, led_ok;

    logic        cur_v, cur_last, out_free, emit_go, emit_end;
    logic [3:0]  cur_led;
    logic [23:0] cur_col;

    rlpe_curve #(.SINE_STEPS(SINE_STEPS)) u_curve (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.curve_start),
        .e_in   (curve_e_reg),
        .len_in (curve_len_reg),
        .done   (curve_done),
        .c_out  (c_val)
    );

    function automatic logic [7:0] ease_chan(input logic [7:0] f, input logic [7:0] t,
                                             input logic [16:0] c);
        logic [7:0]  d;
        logic [24:0] p;
        begin
            if (t >= f)
            begin
                d = t - f;
                p = 25'(d) * 25'(c);
                ease_chan = f + p[23:16];
            end
            else
            begin
                d = f - t;
                p = 25'(d) * 25'(c) + 25'd65535;
                ease_chan = f - p[23:16];
            end
        end
    endfunction

    function automatic logic [7:0] scale_chan(input logic [7:0] v, input logic [16:0] i);
        logic [24:0] p;
        begin
            p = 25'(v) * 25'(i);
            scale_chan = p[23:16];
        end
    endfunction

    function automatic logic [11:0] pwm(input logic [7:0] duty, input logic anode);
        begin
            pwm = anode ? (12'd4095 - {duty, 4'd0}) : {duty, 4'd0};
        end
    endfunction

    assign fade_e     = now_reg - fade_begin_reg;
    assign fade_snap  = (fade_len_reg == 32'd0) || (fade_e >= fade_len_reg);
    assign pulse_e    = now_reg - pulse_begin_reg;
    assign blink_diff = now_reg - deadline_reg;
    assign is_due     = ~blink_diff[31];
    assign pat_led_ok = (pat_led_reg < 8'(LED_COUNT));
    assign led_ok     = (led_reg < 8'(LED_COUNT));
    assign inten      = rising_reg ? c_val : 17'(17'd65536 - c_val);

    assign eased  = {ease_chan(fade_from_reg[23:16], fade_to_reg[23:16], c_val),
                     ease_chan(fade_from_reg[15:8],  fade_to_reg[15:8],  c_val),
                     ease_chan(fade_from_reg[7:0],   fade_to_reg[7:0],   c_val)};
    assign pulsed = {scale_chan(pat_color_reg[23:16], inten),
                     scale_chan(pat_color_reg[15:8],  inten),
                     scale_chan(pat_color_reg[7:0],   inten)};

    assign ch_pos  = ({1'b0, chase_pos_reg} < 5'(LED_COUNT)) ? chase_pos_reg : 4'd0;
    assign ch_prev = (ch_pos == 4'd0) ? LAST_LED : ch_pos - 4'd1;
    assign ch_nxt  = (5'(ch_pos) + 5'd1 == 5'(LED_COUNT)) ? 4'd0 : ch_pos + 4'd1;

    // write emission
    always_comb
    begin
        if (loop_reg)
        begin
            cur_v    = 1'b1;
            cur_led  = 4'(idx_reg);
            cur_col  = loop_color_reg;
            emit_end = (4'(idx_reg) == LAST_LED);
            cur_last = emit_end;
        end
        else
        begin
            cur_v    = slot_v_reg[idx_reg[1:0]];
            cur_led  = slot_led_reg[idx_reg[1:0]];
            cur_col  = slot_col_reg[idx_reg[1:0]];
            emit_end = (idx_reg[1:0] == 2'd2);
            case (idx_reg[1:0])
                2'd0:    cur_last = ~(slot_v_reg[1] | slot_v_reg[2]);
                2'd1:    cur_last = ~slot_v_reg[2];
                default: cur_last = 1'b1;
            endcase
        end
    end

    assign out_free = ~out_v_reg | ~out_stall;
    assign emit_go  = cmd.emit && (~cur_v || out_free);

    always_comb
    begin
        fade_act_next    = fade_act_reg;
        fade_led_next    = fade_led_reg;
        fade_from_next   = fade_from_reg;
        fade_to_next     = fade_to_reg;
        fade_begin_next  = fade_begin_reg;
        fade_len_next    = fade_len_reg;
        mode_next        = mode_reg;
        pat_led_next     = pat_led_reg;
        pat_color_next   = pat_color_reg;
        pat_t1_next      = pat_t1_reg;
        pat_t2_next      = pat_t2_reg;
        deadline_next    = deadline_reg;
        off_phase_next   = off_phase_reg;
        chase_pos_next   = chase_pos_reg;
        pulse_begin_next = pulse_begin_reg;
        rising_next      = rising_reg;
        pulse_last_next  = pulse_last_reg;
        curve_e_next     = curve_e_reg;
        curve_len_next   = curve_len_reg;
        loop_next        = loop_reg;
        loop_color_next  = loop_color_reg;
        slot_v_next      = slot_v_reg;
        slot_led_next    = slot_led_reg;
        slot_col_next    = slot_col_reg;
        idx_next         = idx_reg;

        if (cmd.decode)
        begin
            idx_next        = '0;
            loop_next       = 1'b0;
            loop_color_next = '0;
            slot_v_next     = '0;
            case (rlpe_pkg::kind_t'(kind_reg))
                rlpe_pkg::KIND_SET:
                begin
                    slot_v_next[0]   = led_ok;
                    slot_led_next[0] = led_reg[3:0];
                    slot_col_next[0] = color_reg;
                end
                rlpe_pkg::KIND_ALL:
                begin
                    loop_next       = 1'b1;
                    loop_color_next = color_reg;
                end
                rlpe_pkg::KIND_OFF:
                    loop_next = 1'b1;
                rlpe_pkg::KIND_FADE:
                begin
                    if (led_ok)
                    begin
                        fade_act_next   = 1'b1;
                        fade_led_next   = led_reg[3:0];
                        fade_from_next  = retained_reg[led_reg[LIW-1:0]];
                        fade_to_next    = color_reg;
                        fade_begin_next = now_reg;
                        fade_len_next   = t1_reg;
                    end
                end
                rlpe_pkg::KIND_STOP:
                begin
                    loop_next     = 1'b1;
                    mode_next     = rlpe_pkg::PAT_NONE;
                    fade_act_next = 1'b0;
                end
                rlpe_pkg::KIND_BLINK, rlpe_pkg::KIND_PULSE, rlpe_pkg::KIND_CHASE:
                begin
                    // stop, clear, then start with fresh state based at now
                    loop_next        = 1'b1;
                    fade_act_next    = 1'b0;
                    mode_next        = rlpe_pkg::pat_mode_t'(2'(kind_reg - 4'd5));
                    pat_color_next   = color_reg;
                    pat_t1_next      = t1_reg;
                    deadline_next    = now_reg;
                    off_phase_next   = 1'b0;
                    chase_pos_next   = '0;
                    pulse_last_next  = '0;
                    pat_led_next     = '0;
                    pat_t2_next      = '0;
                    rising_next      = 1'b0;
                    pulse_begin_next = '0;
                    if (rlpe_pkg::kind_t'(kind_reg) == rlpe_pkg::KIND_BLINK)
                    begin
                        pat_led_next = led_reg;
                        pat_t2_next  = t2_reg;
                    end
                    else if (rlpe_pkg::kind_t'(kind_reg) == rlpe_pkg::KIND_PULSE)
                    begin
                        pat_led_next     = led_reg;
                        rising_next      = 1'b1;
                        pulse_begin_next = now_reg;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.fade_prep && fade_act_reg)
        begin
            if (fade_snap)
            begin
                slot_v_next[0]   = 1'b1;
                slot_led_next[0] = fade_led_reg;
                slot_col_next[0] = fade_to_reg;
                fade_act_next    = 1'b0;
            end
            else
            begin
                curve_e_next   = fade_e;
                curve_len_next = fade_len_reg;
            end
        end

        if (cmd.fade_mix)
        begin
            slot_v_next[0]   = 1'b1;
            slot_led_next[0] = fade_led_reg;
            slot_col_next[0] = eased;
        end

        if (cmd.pat_prep)
        begin
            case (mode_reg)
                rlpe_pkg::PAT_BLINK:
                begin
                    if (is_due)
                    begin
                        slot_v_next[1]   = pat_led_ok;
                        slot_led_next[1] = pat_led_reg[3:0];
                        slot_col_next[1] = off_phase_reg ? 24'd0 : pat_color_reg;
                        deadline_next    = now_reg + (off_phase_reg ? pat_t2_reg : pat_t1_reg);
                        off_phase_next   = ~off_phase_reg;
                    end
                end
                rlpe_pkg::PAT_PULSE:
                begin
                    if (pat_t1_reg != 32'd0)
                    begin
                        curve_len_next = pat_t1_reg;
                        curve_e_next   = pulse_e;
                        if (pulse_e >= pat_t1_reg)
                        begin
                            rising_next      = ~rising_reg;
                            pulse_begin_next = now_reg;
                            curve_e_next     = '0;
                        end
                    end
                end
                rlpe_pkg::PAT_CHASE:
                begin
                    if (is_due)
                    begin
                        slot_v_next[1]   = 1'b1;
                        slot_led_next[1] = ch_prev;
                        slot_col_next[1] = '0;
                        slot_v_next[2]   = 1'b1;
                        slot_led_next[2] = ch_pos;
                        slot_col_next[2] = pat_color_reg;
                        chase_pos_next   = ch_nxt;
                        deadline_next    = now_reg + pat_t1_reg;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.pulse_mix && (pulsed != pulse_last_reg))
        begin
            slot_v_next[1]   = pat_led_ok;
            slot_led_next[1] = pat_led_reg[3:0];
            slot_col_next[1] = pulsed;
            pulse_last_next  = pulsed;
        end

        if (emit_go)
            idx_next = idx_reg + IW'(1);
    end

    assign status.is_tick     = (rlpe_pkg::kind_t'(kind_reg) == rlpe_pkg::KIND_TICK);
    assign status.fade_curve  = fade_act_reg && !fade_snap;
    assign status.pulse_curve = (mode_reg == rlpe_pkg::PAT_PULSE) && (pat_t1_reg != 32'd0);
    assign status.curve_done  = curve_done;
    assign status.emit_go     = emit_go;
    assign status.emit_end    = emit_end;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            now_reg   <= now_ms;
            led_reg   <= led_index;
            color_reg <= {red, green, blue};
            t1_reg    <= time_first;
            t2_reg    <= time_second;
        end
        if (emit_go && cur_v)
        begin
            out_led_reg  <= cur_led;
            out_chan_reg <= 6'(start_chan_reg) + 6'(cur_led) * 6'd3;
            out_r_reg    <= pwm(cur_col[23:16], anode_reg);
            out_g_reg    <= pwm(cur_col[15:8], anode_reg);
            out_b_reg    <= pwm(cur_col[7:0], anode_reg);
            out_last_reg <= cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anode_reg       <= 1'b0;
            start_chan_reg  <= '0;
            for (int i = 0; i < LED_COUNT; i++)
                retained_reg[i] <= '0;
            fade_act_reg    <= 1'b0;
            fade_led_reg    <= '0;
            fade_from_reg   <= '0;
            fade_to_reg     <= '0;
            fade_begin_reg  <= '0;
            fade_len_reg    <= '0;
            mode_reg        <= rlpe_pkg::PAT_NONE;
            pat_led_reg     <= '0;
            pat_color_reg   <= '0;
            pat_t1_reg      <= '0;
            pat_t2_reg      <= '0;
            deadline_reg    <= '0;
            off_phase_reg   <= 1'b0;
            chase_pos_reg   <= '0;
            pulse_begin_reg <= '0;
            rising_reg      <= 1'b0;
            pulse_last_reg  <= '0;
            curve_e_reg     <= '0;
            curve_len_reg   <= '0;
            loop_reg        <= 1'b0;
            loop_color_reg  <= '0;
            slot_v_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                slot_led_reg[i] <= '0;
                slot_col_reg[i] <= '0;
            end
            idx_reg         <= '0;
            out_v_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == rlpe_pkg::CFG_COMMON_ANODE)
                    anode_reg <= cfg_data[0];
                else
                    start_chan_reg <= cfg_data;
            end
            if (emit_go && cur_v)
                retained_reg[cur_led[LIW-1:0]] <= cur_col;
            fade_act_reg    <= fade_act_next;
            fade_led_reg    <= fade_led_next;
            fade_from_reg   <= fade_from_next;
            fade_to_reg     <= fade_to_next;
            fade_begin_reg  <= fade_begin_next;
            fade_len_reg    <= fade_len_next;
            mode_reg        <= mode_next;
            pat_led_reg     <= pat_led_next;
            pat_color_reg   <= pat_color_next;
            pat_t1_reg      <= pat_t1_next;
            pat_t2_reg      <= pat_t2_next;
            deadline_reg    <= deadline_next;
            off_phase_reg   <= off_phase_next;
            chase_pos_reg   <= chase_pos_next;
            pulse_begin_reg <= pulse_begin_next;
            rising_reg      <= rising_next;
            pulse_last_reg  <= pulse_last_next;
            curve_e_reg     <= curve_e_next;
            curve_len_reg   <= curve_len_next;
            loop_reg        <= loop_next;
            loop_color_reg  <= loop_color_next;
            slot_v_reg      <= slot_v_next;
            slot_led_reg    <= slot_led_next;
            slot_col_reg    <= slot_col_next;
            idx_reg         <= idx_next;
            if (emit_go && cur_v)
                out_v_reg <= 1'b1;
            else if (!out_stall)
                out_v_reg <= 1'b0;
        end
    end

    assign out_valid     = out_v_reg;
    assign written_led   = out_led_reg;
    assign first_channel = out_chan_reg;
    assign red_pwm       = out_r_reg;
    assign green_pwm     = out_g_reg;
    assign blue_pwm      = out_b_reg;
    assign last          = out_last_reg;

endmodule

// ===== rtl/rgb_led_pattern_engine_top.sv =====
// ----------------------------------------------------------------------------
// rgb_led_pattern_engine_top
// RGB LED pattern engine: keeps each LED's colour, runs a sine-eased fade and
// blink, pulse and chase patterns, and issues one PWM item per LED write.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | kind, now_ms, led_index, red, green, blue,
//          |                    | time_first, time_second
//  out     | out_valid/out_stall| written_led, first_channel, red_pwm,
//          |                    | green_pwm, blue_pwm, last
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One item at a time. A command passes through accept and decode, then its
//  emission: one write per LED for set-all, off, stop and pattern starts, the
//  three write slots for the rest. A tick also runs the curve for a fade in
//  progress and for an active pulse: one 17-step restoring division, a
//  reciprocal scale and five multiply steps set the curve figure. Writes leave
//  through a single output register; while it is full and stalled, emission holds.
//  Reset clears all colours and fade/pattern state; there is no clearing pass.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module rgb_led_pattern_engine_top #(
    parameter int LED_COUNT  = 5,
    parameter int SINE_STEPS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  kind,
    input  logic [31:0] now_ms,
    input  logic [7:0]  led_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [31:0] time_first,
    input  logic [31:0] time_second,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  written_led,
    output logic [5:0]  first_channel,
    output logic [11:0] red_pwm,
    output logic [11:0] green_pwm,
    output logic [11:0] blue_pwm,
    output logic        last,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    rlpe_pkg::ctrl_cmd_t  cmd;
    rlpe_pkg::dp_status_t status;

    // inputs are taken only when the sequencer is idle
    assign in_stall  = ~cmd.ready;
    assign cfg_ready = 1'b1;

    rlpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd)
    );

    rlpe_dp #(
        .LED_COUNT  (LED_COUNT),
        .SINE_STEPS (SINE_STEPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (kind),
        .now_ms        (now_ms),
        .led_index     (led_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .time_first    (time_first),
        .time_second   (time_second),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .written_led   (written_led),
        .first_channel (first_channel),
        .red_pwm       (red_pwm),
        .green_pwm     (green_pwm),
        .blue_pwm      (blue_pwm),
        .last          (last)
    );

endmodule
